FILE: hdl/brm_pkg.sv
// Shared types, decode addresses and tables for the banked ROM mapper.
package brm_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 5;

    localparam logic [15:0] ADDR_PRG0     = 16'h8800;
    localparam logic [15:0] ADDR_PRG1     = 16'hA800;
    localparam logic [15:0] ADDR_PRG2     = 16'hA000;
    localparam logic [15:0] ADDR_CHR_LO   = 16'hB000;
    localparam logic [15:0] ADDR_CHR_HI   = 16'hE00F;
    localparam logic [15:0] ADDR_CHR_MASK = 16'h0FF3;
    localparam logic [3:0]  CHR_BASE_NIB  = 4'hB;
    localparam logic [3:0]  IRQ_PAGE_NIB  = 4'hF;
    localparam logic [15:0] ADDR_RESET    = 16'h9008;
    localparam logic [15:0] ADDR_MIRROR   = 16'h9800;
    localparam logic [15:0] ADDR_IRQ_LO   = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_HI   = 16'hF004;
    localparam logic [15:0] ADDR_IRQ_EN   = 16'hF008;

    localparam logic [7:0] RESET_CMD_DATA  = 8'h01;
    localparam logic [7:0] LAST_PRG_RESET  = 8'd15;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [1:0] KIND_PRG_8K  = 2'd0;
    localparam logic [1:0] KIND_PRG_16K = 2'd1;
    localparam logic [1:0] KIND_CHR_1K  = 2'd2;
    localparam logic [1:0] KIND_CHR_8K  = 2'd3;

    typedef struct packed {
        logic       swap_valid;
        logic [1:0] swap_kind;
        logic [2:0] swap_slot;
        logic [7:0] swap_bank;
        logic       mirror_valid;
        logic [3:0] nametable;   // bit n is logical table n
        logic       irq_fire;
        logic       last_of_run;
    } result_t;

    function automatic logic [3:0] mirror_pattern(input logic [1:0] sel);
        logic [3:0] pat;
        case (sel)
            2'd0: pat = 4'b1010;
            2'd1: pat = 4'b1100;
            2'd2: pat = 4'b0000;
            2'd3: pat = 4'b1111;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

FILE: hdl/banked_rom_mapper_with_irq_counter.sv
// Top level of the banked ROM mapper with bank swap commands and IRQ down-counter.
//
// Input channel s_*: one word per CPU bus write (s_tuser 0) or per time tick (s_tuser 1).
// Result channel m_*: bank swap, mirroring or IRQ words; m_tlast marks the final word
// of one input word. Configuration channel cfg_*: the last 16K PRG bank, always ready.
// A word accepted on s_* lands in the input register and is decoded from there; its
// results are registered in the result register, which drives m_tvalid and the
// other m_* signals. Words that cause no result still pass through the decode stage.
// Throughput is one input word per cycle unless the receiver stalls or a bank reset
// command is pending. The bank reset command (data 1 at 0x9008) emits three result
// words and holds the decode stage while the last two are sent.
// When the receiver stalls, the result register holds its word and the input
// register takes one more word, if it is empty, before s_tready drops.
// Reset clears the CHR bank registers, the IRQ counter and enable, all valid flags,
// and sets the last 16K PRG bank to 15.
module banked_rom_mapper_with_irq_counter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address [15:0], write_data [23:16], tick_cycles [35:24]
    input  logic [brm_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // swap_slot [2:0], swap_bank [10:3], nametable_0..3 [14:11]
    output logic [brm_pkg::M_TDATA_W-1:0]  m_tdata,
    // swap_valid [0], swap_kind [2:1], mirror_valid [3], irq_fire [4]
    output logic [brm_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [7:0]                     cfg_data
);
    import brm_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic        in_mode_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;
    logic [11:0] in_cycles_reg;

    logic [7:0]  chr_reg  [CHR_SLOTS];
    logic [7:0]  chr_next [CHR_SLOTS];
    logic [15:0] irq_cnt_reg, irq_cnt_next;
    logic        irq_en_reg, irq_en_next;
    logic [7:0]  last_prg_reg;

    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  pend_reg, pend_next;

    logic                 out_free;
    logic                 proc;
    logic                 chr_hit;
    logic [3:0]           chr_page;
    logic [CHR_IDX_W-1:0] chr_idx;
    logic [7:0]           chr_new;
    logic                 reset_cmd;
    result_t              res;
    logic                 res_has;

    assign out_free  = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && out_free && (pend_reg == 2'd0);
    assign s_tready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    assign chr_page = in_addr_reg[15:12] - CHR_BASE_NIB;
    assign chr_idx  = {chr_page[1:0], in_addr_reg[3]};
    assign chr_hit  = (in_addr_reg >= ADDR_CHR_LO) && (in_addr_reg <= ADDR_CHR_HI) &&
                      ((in_addr_reg & ADDR_CHR_MASK) == 16'h0000) &&
                      (in_addr_reg[15:12] != IRQ_PAGE_NIB);
    assign chr_new  = in_addr_reg[2] ? {in_data_reg[3:0], chr_reg[chr_idx][3:0]}
                                     : {chr_reg[chr_idx][7:4], in_data_reg[3:0]};
    assign reset_cmd = (in_mode_reg == MODE_WRITE) && (in_addr_reg == ADDR_RESET) &&
                       (in_data_reg == RESET_CMD_DATA);

    always_comb begin
        res     = '0;
        res_has = 1'b0;
        chr_next    = chr_reg;
        irq_cnt_next = irq_cnt_reg;
        irq_en_next  = irq_en_reg;
        if (proc) begin
            if (in_mode_reg == MODE_TICK) begin
                if (irq_en_reg) begin
                    if (irq_cnt_reg <= {4'b0000, in_cycles_reg}) begin
                        irq_cnt_next = 16'h0000;
                        res.irq_fire = 1'b1;
                        res_has      = 1'b1;
                    end else begin
                        irq_cnt_next = irq_cnt_reg - {4'b0000, in_cycles_reg};
                    end
                end
            end else if (in_addr_reg == ADDR_PRG0 || in_addr_reg == ADDR_PRG1 ||
                         in_addr_reg == ADDR_PRG2) begin
                res.swap_valid = 1'b1;
                res.swap_kind  = KIND_PRG_8K;
                res.swap_slot  = (in_addr_reg == ADDR_PRG0) ? 3'd0 :
                                 (in_addr_reg == ADDR_PRG1) ? 3'd1 : 3'd2;
                res.swap_bank  = in_data_reg;
                res_has        = 1'b1;
            end else if (chr_hit) begin
                chr_next[chr_idx] = chr_new;
                res.swap_valid = 1'b1;
                res.swap_kind  = KIND_CHR_1K;
                res.swap_slot  = 3'(chr_idx);
                res.swap_bank  = chr_new;
                res_has        = 1'b1;
            end else if (reset_cmd) begin
                for (int i = 0; i < CHR_SLOTS; i++) begin
                    chr_next[i] = 8'h00;
                end
                res.swap_valid = 1'b1;
                res.swap_kind  = KIND_PRG_16K;
                res_has        = 1'b1;
            end else if (in_addr_reg == ADDR_MIRROR) begin
                if (in_data_reg[7:2] == 6'd0) begin
                    res.mirror_valid = 1'b1;
                    res.nametable    = mirror_pattern(in_data_reg[1:0]);
                    res_has          = 1'b1;
                end
            end else if (in_addr_reg == ADDR_IRQ_LO) begin
                irq_cnt_next = {irq_cnt_reg[15:8], in_data_reg};
            end else if (in_addr_reg == ADDR_IRQ_HI) begin
                irq_cnt_next = {in_data_reg, irq_cnt_reg[7:0]};
            end else if (in_addr_reg == ADDR_IRQ_EN) begin
                irq_en_next = in_data_reg[1];
            end
        end
        res.last_of_run = res_has && !reset_cmd;
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        in_valid_next  = in_valid_reg;
        if (out_free) begin
            if (pend_reg != 2'd0) begin
                out_next            = '0;
                out_next.swap_valid = 1'b1;
                out_valid_next      = 1'b1;
                pend_next           = pend_reg - 2'd1;
                if (pend_reg == 2'd2) begin
                    out_next.swap_kind = KIND_PRG_16K;
                    out_next.swap_slot = 3'd1;
                    out_next.swap_bank = last_prg_reg;
                end else begin
                    out_next.swap_kind   = KIND_CHR_8K;
                    out_next.last_of_run = 1'b1;
                end
            end else begin
                out_next       = res;
                out_valid_next = proc && res_has;
                pend_next      = (proc && reset_cmd) ? 2'd2 : 2'd0;
            end
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 2'd0;
            irq_cnt_reg   <= 16'h0000;
            irq_en_reg    <= 1'b0;
            last_prg_reg  <= LAST_PRG_RESET;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                chr_reg[i] <= 8'h00;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            irq_cnt_reg   <= irq_cnt_next;
            irq_en_reg    <= irq_en_next;
            chr_reg       <= chr_next;
            if (cfg_valid && cfg_ready) begin
                last_prg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg   <= s_tuser;
            in_addr_reg   <= s_tdata[15:0];
            in_data_reg   <= s_tdata[23:16];
            in_cycles_reg <= s_tdata[35:24];
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last_of_run;
    assign m_tdata  = {1'b0, out_reg.nametable, out_reg.swap_bank, out_reg.swap_slot};
    assign m_tuser  = {out_reg.irq_fire, out_reg.mirror_valid, out_reg.swap_kind,
                       out_reg.swap_valid};

endmodule

FILE: hdl/brm_checker.sv
// Port-level checker for the banked ROM mapper, bound to the top level.
module brm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [brm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [brm_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                           m_tlast
);
    import brm_pkg::*;

    // hold a stalled word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("stalled result word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot({m_tuser[4], m_tuser[3], m_tuser[0]}))
        else $error("result word carries not exactly one kind of content");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[4] || m_tuser[3]) |-> m_tlast)
        else $error("mirror or IRQ word not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tuser[2:1] == KIND_PRG_16K |-> !m_tlast)
        else $error("PRG 16K swap marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] && m_tuser[2:1] == KIND_PRG_16K &&
        m_tdata[2:0] == 3'd1 |=> m_tvalid && m_tuser[0] && m_tuser[2:1] == KIND_CHR_8K)
        else $error("bank reset sequence broken");

endmodule

bind banked_rom_mapper_with_irq_counter brm_checker u_brm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
